// ----- src/json_stream_pretty_printer_defines.svh -----
// Assertion helpers used by the checker module.
`ifndef JSON_STREAM_PRETTY_PRINTER_DEFINES_SVH
`define JSON_STREAM_PRETTY_PRINTER_DEFINES_SVH

// Clocked property, quiet while reset is asserted.
`define JSPP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen.
`define JSPP_NEVER(lbl, cond, msg) \
	`JSPP_ASSERT(lbl, !(cond), msg)

`endif

// ----- src/jspp_pkg.sv -----
package jspp_pkg;

	localparam int unsigned MaxRes = 7;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_NL   = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
		logic [7:0] lvl;
	} res_t;

	// all results caused by one input word
	typedef struct packed {
		logic [2:0]            cnt;
		res_t [MaxRes-1:0]     res;
	} batch_t;

	typedef struct packed {
		logic [2:0]       n;
		logic [5:0][7:0]  b;
	} code_seq_t;

	function automatic res_t mk_byte(logic [7:0] c);
		res_t r;
		r.kind = KIND_BYTE;
		r.ch   = c;
		r.lvl  = 8'd0;
		return r;
	endfunction

	function automatic res_t mk_nl(logic [7:0] lvl);
		res_t r;
		r.kind = KIND_NL;
		r.ch   = 8'd0;
		r.lvl  = lvl;
		return r;
	endfunction

	function automatic res_t mk_end();
		res_t r;
		r.kind = KIND_END;
		r.ch   = 8'd0;
		r.lvl  = 8'd0;
		return r;
	endfunction

	function automatic logic [7:0] hex_upper(logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
	endfunction

	function automatic logic [3:0] nibble(logic [7:0] c);
		logic [7:0] t;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
		end else begin
			t = c - 8'h37;
		end
		return t[3:0];
	endfunction

	// Re-encode a decoded code point as escaped text or UTF-8.
	function automatic code_seq_t put_code(logic [20:0] cp);
		code_seq_t s;
		s = '0;
		if (cp == 21'h22 || cp == 21'h5C) begin
			s.n = 3'd2; s.b[0] = 8'h5C; s.b[1] = cp[7:0];
		end else if (cp < 21'h20) begin
			s.n = 3'd6;
			s.b[0] = 8'h5C; s.b[1] = 8'h75; s.b[2] = 8'h30; s.b[3] = 8'h30;
			s.b[4] = hex_upper({3'd0, cp[4]});
			s.b[5] = hex_upper(cp[3:0]);
		end else if (cp >= 21'hD800 && cp <= 21'hDFFF) begin
			s.n = 3'd3; s.b[0] = 8'hEF; s.b[1] = 8'hBF; s.b[2] = 8'hBD;
		end else if (cp < 21'h80) begin
			s.n = 3'd1; s.b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			s.n = 3'd2;
			s.b[0] = {3'b110, cp[10:6]};
			s.b[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			s.n = 3'd3;
			s.b[0] = {4'b1110, cp[15:12]};
			s.b[1] = {2'b10, cp[11:6]};
			s.b[2] = {2'b10, cp[5:0]};
		end else begin
			s.n = 3'd4;
			s.b[0] = {5'b11110, cp[20:18]};
			s.b[1] = {2'b10, cp[17:12]};
			s.b[2] = {2'b10, cp[11:6]};
			s.b[3] = {2'b10, cp[5:0]};
		end
		return s;
	endfunction

endpackage

// ----- src/jspp_stream_if.sv -----
interface jspp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       stream_end;

	modport source (output valid, output in_byte, output stream_end, input ready);
	modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface jspp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_char;
	logic [7:0] indent_level;
	logic       run_last;

	modport source (output valid, output out_kind, output out_char,
		output indent_level, output run_last, input ready);
	modport sink   (input valid, input out_kind, input out_char,
		input indent_level, input run_last, output ready);
endinterface

// ----- src/jspp_front.sv -----
module jspp_front
	import jspp_pkg::*;
#(
	parameter int unsigned MAX_DEPTH = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       stream_end,
	input  logic       q_full,
	output logic       push,
	output batch_t     push_batch
);

	localparam int unsigned DW = (MAX_DEPTH < 2) ? 1 : $clog2(MAX_DEPTH + 1);
	localparam logic [DW-1:0] DepthMax = DW'(MAX_DEPTH);

	localparam logic [2:0] PH_OUT   = 3'd0;
	localparam logic [2:0] PH_STR   = 3'd1;
	localparam logic [2:0] PH_ESC   = 3'd2;
	localparam logic [2:0] PH_HEX   = 3'd3;
	localparam logic [2:0] PH_SKIP1 = 3'd4;
	localparam logic [2:0] PH_SKIP2 = 3'd5;
	localparam logic [2:0] PH_LOW   = 3'd6;

	logic          compact_q;
	logic [DW-1:0] depth_q, depth_n;
	logic [2:0]    phase_q, phase_n;
	logic [1:0]    hex_q, hex_n;
	logic [15:0]   acc_q, acc_n;
	logic [9:0]    hs_q, hs_n;
	logic          open_q, open_n;
	logic          brk_q, brk_n;

	function automatic logic [7:0] indent(logic [DW-1:0] d);
		return (32'(d) > 32'd255) ? 8'hFF : 8'(d);
	endfunction

	assign in_ready = !q_full;

	always_comb begin
		logic [7:0]     c;
		logic [2:0]     n;
		batch_t         b;
		logic           do_out;
		logic           sp;
		logic [7:0]     opn, cls;
		code_seq_t      cs;
		logic           emit_code;

		c         = in_byte;
		n         = 3'd0;
		b         = '0;
		do_out    = 1'b0;
		emit_code = 1'b0;
		cs        = '0;
		sp        = c inside {8'h20, [8'h09:8'h0D]};
		opn       = brk_q ? 8'h5B : 8'h7B;
		cls       = brk_q ? 8'h5D : 8'h7D;

		depth_n = depth_q;
		phase_n = phase_q;
		hex_n   = hex_q;
		acc_n   = acc_q;
		hs_n    = hs_q;
		open_n  = open_q;
		brk_n   = brk_q;

		if (open_q) begin
			if (sp) begin
				// hold the open until something real turns up
			end else if (c == cls) begin
				b.res[n] = mk_byte(opn); n = n + 3'd1;
				b.res[n] = mk_byte(cls); n = n + 3'd1;
				open_n = 1'b0;
			end else begin
				b.res[n] = mk_byte(opn); n = n + 3'd1;
				if (depth_n < DepthMax) depth_n = depth_n + 1'b1;
				if (!compact_q) begin
					b.res[n] = mk_nl(indent(depth_n)); n = n + 3'd1;
				end
				open_n = 1'b0;
				do_out = 1'b1;
			end
		end else if (phase_q == PH_OUT) begin
			do_out = 1'b1;
		end else begin
			case (phase_q)
				PH_STR: begin
					if (c == 8'h5C) begin
						phase_n = PH_ESC;
					end else begin
						b.res[n] = mk_byte(c); n = n + 3'd1;
						if (c == 8'h22) phase_n = PH_OUT;
					end
				end
				PH_ESC: begin
					if (c == 8'h75) begin
						phase_n = PH_HEX;
						hex_n   = 2'd0;
						acc_n   = 16'd0;
					end else begin
						if (c != 8'h2F) begin
							b.res[n] = mk_byte(8'h5C); n = n + 3'd1;
						end
						b.res[n] = mk_byte(c); n = n + 3'd1;
						phase_n = PH_STR;
					end
				end
				PH_HEX, PH_LOW: begin
					acc_n = {acc_q[11:0], nibble(c)};
					if (hex_q != 2'd3) begin
						hex_n = hex_q + 2'd1;
					end else begin
						hex_n = 2'd0;
						if (phase_q == PH_HEX) begin
							if (acc_n >= 16'hD800 && acc_n <= 16'hDBFF) begin
								hs_n    = acc_n[9:0];
								phase_n = PH_SKIP1;
							end else begin
								cs        = put_code({5'd0, acc_n});
								emit_code = 1'b1;
								phase_n   = PH_STR;
							end
						end else begin
							cs        = put_code(21'h10000 + {1'b0, hs_q, acc_n[9:0]});
							emit_code = 1'b1;
							phase_n   = PH_STR;
						end
						acc_n = 16'd0;
					end
				end
				PH_SKIP1: phase_n = PH_SKIP2;
				PH_SKIP2: begin
					phase_n = PH_LOW;
					hex_n   = 2'd0;
					acc_n   = 16'd0;
				end
				default: phase_n = PH_OUT;
			endcase
		end

		if (emit_code) begin
			for (int i = 0; i < 6; i++) begin
				if (3'(i) < cs.n) begin
					b.res[n] = mk_byte(cs.b[i]); n = n + 3'd1;
				end
			end
		end

		if (do_out) begin
			if (c == 8'h22) begin
				b.res[n] = mk_byte(c); n = n + 3'd1;
				phase_n = PH_STR;
			end else if (c == 8'h7B || c == 8'h5B) begin
				open_n = 1'b1;
				brk_n  = (c == 8'h5B);
			end else if (c == 8'h7D || c == 8'h5D) begin
				if (depth_n != '0) depth_n = depth_n - 1'b1;
				if (!compact_q) begin
					b.res[n] = mk_nl(indent(depth_n)); n = n + 3'd1;
				end
				b.res[n] = mk_byte(c); n = n + 3'd1;
			end else if (c == 8'h2C) begin
				b.res[n] = mk_byte(c); n = n + 3'd1;
				if (!compact_q) begin
					b.res[n] = mk_nl(indent(depth_n)); n = n + 3'd1;
				end
			end else if (c == 8'h3A) begin
				b.res[n] = mk_byte(c); n = n + 3'd1;
				if (!compact_q) begin
					b.res[n] = mk_byte(8'h20); n = n + 3'd1;
				end
			end else if (!sp) begin
				b.res[n] = mk_byte(c); n = n + 3'd1;
			end
		end

		if (stream_end) begin
			// flush a held open, then close the text and drop all state but compact mode
			if (open_n) begin
				b.res[n] = mk_byte(brk_n ? 8'h5B : 8'h7B); n = n + 3'd1;
				if (depth_n < DepthMax) depth_n = depth_n + 1'b1;
				if (!compact_q) begin
					b.res[n] = mk_nl(indent(depth_n)); n = n + 3'd1;
				end
			end
			b.res[n] = mk_end(); n = n + 3'd1;
			depth_n = '0;
			phase_n = PH_OUT;
			hex_n   = 2'd0;
			acc_n   = 16'd0;
			hs_n    = 10'd0;
			open_n  = 1'b0;
			brk_n   = 1'b0;
		end

		b.cnt      = n;
		push_batch = b;
		push       = in_valid && in_ready && (n != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compact_q <= 1'b0;
			depth_q   <= '0;
			phase_q   <= PH_OUT;
			hex_q     <= 2'd0;
			acc_q     <= 16'd0;
			hs_q      <= 10'd0;
			open_q    <= 1'b0;
			brk_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) compact_q <= cfg_wr_data;
			if (in_valid && in_ready) begin
				depth_q <= depth_n;
				phase_q <= phase_n;
				hex_q   <= hex_n;
				acc_q   <= acc_n;
				hs_q    <= hs_n;
				open_q  <= open_n;
				brk_q   <= brk_n;
			end
		end
	end

endmodule

// ----- src/jspp_queue.sv -----
module jspp_queue
	import jspp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  batch_t push_batch,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output batch_t head
);

	batch_t     mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_batch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- src/jspp_back.sv -----
module jspp_back
	import jspp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  batch_t     head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] out_kind,
	output logic [7:0] out_char,
	output logic [7:0] indent_level,
	output logic       run_last
);

	logic [2:0] idx_q;
	res_t       cur;
	logic       last;

	assign cur          = head.res[idx_q];
	assign last         = (idx_q == head.cnt - 3'd1);
	assign out_valid    = head_valid;
	assign out_kind     = cur.kind;
	assign out_char     = cur.ch;
	assign indent_level = cur.lvl;
	assign run_last     = last;
	assign pop          = out_valid && out_ready && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
		end else if (out_valid && out_ready) begin
			// advance through the batch, back to the start once it is spent
			idx_q <= last ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule

// ----- src/json_stream_pretty_printer.sv -----
// channel  | direction | word
// ---------+-----------+-----------------------------------------------
// in_ch    | in        | in_byte, stream_end
// out_ch   | out       | out_kind, out_char, indent_level, run_last
// cfg      | in        | cfg_wr_en, cfg_wr_data (compact mode)
//
// One input word per cycle; each word yields 0 to 7 output words, sent one
// per cycle while out_ch.ready is high, from a two-batch queue.
// An input word is decoded in the cycle it is taken; the earliest result shows
// the next cycle. Input stalls only when both queue slots hold batches.
// Reset clears all state, the queue and compact mode at once.
module json_stream_pretty_printer
	import jspp_pkg::*;
#(
	parameter int unsigned MAX_DEPTH = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	jspp_in_if.sink    in_ch,
	jspp_out_if.source out_ch
);

	logic   push, full, pop, head_valid;
	batch_t push_batch, head;

	jspp_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_byte    (in_ch.in_byte),
		.stream_end (in_ch.stream_end),
		.q_full     (full),
		.push       (push),
		.push_batch (push_batch)
	);

	jspp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_batch(push_batch),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	jspp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_kind    (out_ch.out_kind),
		.out_char    (out_ch.out_char),
		.indent_level(out_ch.indent_level),
		.run_last    (out_ch.run_last)
	);

endmodule

// ----- src/jspp_checker.sv -----
`include "json_stream_pretty_printer_defines.svh"

module jspp_checker
	import jspp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_char,
	input logic [7:0] indent_level,
	input logic       run_last
);

	`JSPP_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_char) && $stable(indent_level) && $stable(run_last)), "stalled output word changed")
	`JSPP_NEVER(a_end_not_last, out_valid && out_kind == KIND_END && !run_last, "end marker not last word of its run")
	`JSPP_NEVER(a_nl_char, out_valid && out_kind == KIND_NL && out_char != 8'd0, "newline marker carries a byte")
	`JSPP_NEVER(a_byte_lvl, out_valid && out_kind == KIND_BYTE && indent_level != 8'd0, "literal byte carries a depth")

endmodule

bind json_stream_pretty_printer jspp_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_kind    (out_ch.out_kind),
	.out_char    (out_ch.out_char),
	.indent_level(out_ch.indent_level),
	.run_last    (out_ch.run_last)
);
